[design/arpc_pkg.sv]
// Shared types and codes for the address cache with request retry.
package arpc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN,
        S_PUPD,
        S_CSCAN,
        S_TWALK
    } t_state;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUEUE  = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_QUEUE  = 3'd2;
    localparam logic [2:0] KIND_SEND   = 3'd3;
    localparam logic [2:0] KIND_UNREACH = 3'd4;

    localparam logic [1:0] QS_NEW     = 2'd0;
    localparam logic [1:0] QS_PENDING = 2'd1;
    localparam logic [1:0] QS_FULL    = 2'd2;

    localparam logic CFG_ENTRY_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_SENDS     = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15;
    localparam logic [3:0]  MAX_SENDS_RESET = 4'd5;

    // Cache addresses are carried at the widest supported depth (256)
    typedef struct packed {
        logic [7:0]  rd_addr;
        logic [7:0]  wr_addr;
        logic        wr_new;
        logic        wr_age_en;
        logic        clr;
        logic [31:0] wr_ip;
        logic [47:0] wr_mac;
        logic [15:0] wr_age;
    } t_cache_ctl;

endpackage

[design/arpc_cache.sv]
// Cache entry storage: address, hardware address and age memories plus valid bits.
module arpc_cache #(
    parameter int CACHE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arpc_pkg::t_cache_ctl i_ctl,
    output logic               o_rd_valid,
    output logic [31:0]        o_rd_ip,
    output logic [47:0]        o_rd_mac,
    output logic [15:0]        o_rd_age
);
    import arpc_pkg::*;

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    logic [31:0] mem_ip  [CACHE_DEPTH];
    logic [47:0] mem_mac [CACHE_DEPTH];
    logic [15:0] mem_age [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] r_valid;

    logic [AW-1:0] rd_a;
    logic [AW-1:0] wr_a;

    assign rd_a = i_ctl.rd_addr[AW-1:0];
    assign wr_a = i_ctl.wr_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_new) begin
            mem_ip[wr_a]  <= i_ctl.wr_ip;
            mem_mac[wr_a] <= i_ctl.wr_mac;
        end
        if (i_ctl.wr_new || i_ctl.wr_age_en) begin
            mem_age[wr_a] <= i_ctl.wr_age;
        end
        o_rd_ip    <= mem_ip[rd_a];
        o_rd_mac   <= mem_mac[rd_a];
        o_rd_age   <= mem_age[rd_a];
        o_rd_valid <= r_valid[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_new) begin
            r_valid[wr_a] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_valid[wr_a] <= 1'b0;
        end
    end

endmodule

[design/arp_cache_with_request_retry.sv]
// Top level: command sequencer, pending request table and result register.
//
// Usage: drive i_cmd/i_ip/i_mac with i_start high; the command is taken at an
// edge where o_busy is low. Lookup, insert and queue give exactly one result;
// a tick gives one result per pending request, none if there are none. Each
// result shows on the o_ ports for one cycle with o_valid high, and o_last
// marks the final one of a command. The receiver cannot stall.
// A lookup scans every cache entry through one address compare. Queue walks
// the pending slots. Insert walks the pending slots and then the cache. A
// tick ages the cache in one scan and then emits one result per pending
// request per cycle. One command is handled at a time; o_busy is high
// until its last result.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at once;
// the user makes them only while o_busy is low; the block does not enforce it.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed.
module arp_cache_with_request_retry #(
    parameter int CACHE_DEPTH   = 64,
    parameter int PENDING_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_ip,
    input  logic [47:0] i_mac,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic        o_found,
    output logic        o_stored,
    output logic [1:0]  o_queue_status,
    output logic [47:0] o_mac_out,
    output logic [31:0] o_ip_out,
    output logic        o_last
);
    import arpc_pkg::*;

    localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    t_state r_state, n_state;

    logic [1:0]  r_cmd;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [15:0] r_timeout;
    logic [3:0]  r_max;

    logic [CAW:0]   r_cidx, n_cidx;
    logic           r_pv, n_pv;
    logic [CAW-1:0] r_paddr, n_paddr;
    logic           r_hit, n_hit;
    logic [47:0]    r_hmac, n_hmac;
    logic           r_stored, n_stored;

    logic [PAW-1:0] r_pidx, n_pidx;
    logic           r_pmatch, n_pmatch;
    logic [PAW-1:0] r_pslot, n_pslot;
    logic           r_pfree_ok, n_pfree_ok;
    logic [PAW-1:0] r_pfree, n_pfree;
    logic [PAW:0]   r_rank, n_rank;
    logic [PAW-1:0] r_next, n_next;

    logic [PENDING_DEPTH-1:0] r_q_valid, n_q_valid;
    logic [31:0]    r_q_ip    [PENDING_DEPTH];
    logic [31:0]    n_q_ip    [PENDING_DEPTH];
    logic [3:0]     r_q_sends [PENDING_DEPTH];
    logic [3:0]     n_q_sends [PENDING_DEPTH];
    logic [PAW-1:0] r_q_rank  [PENDING_DEPTH];
    logic [PAW-1:0] n_q_rank  [PENDING_DEPTH];

    logic        r_out_stb, n_out_stb;
    logic [2:0]  r_kind, n_kind;
    logic        r_found, n_found;
    logic        r_ostored, n_ostored;
    logic [1:0]  r_qs, n_qs;
    logic [47:0] r_omac, n_omac;
    logic [31:0] r_oip, n_oip;
    logic        r_last, n_last;

    t_cache_ctl  cctl;
    logic        c_valid;
    logic [31:0] c_ip;
    logic [47:0] c_mac;
    logic [15:0] c_age;

    logic           accept;
    logic           cscan_done;
    logic           pscan_end;
    logic           any0, any1;
    logic [PAW-1:0] sel;
    logic [16:0]    age_inc;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);
    assign cscan_done = (r_cidx == (CAW+1)'(CACHE_DEPTH)) && !r_pv;
    assign pscan_end = (r_pidx == PAW'(PENDING_DEPTH - 1));
    assign age_inc = {1'b0, c_age} + 17'd1;

    arpc_cache #(.CACHE_DEPTH(CACHE_DEPTH)) u_cache (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cctl),
        .o_rd_valid (c_valid),
        .o_rd_ip    (c_ip),
        .o_rd_mac   (c_mac),
        .o_rd_age   (c_age)
    );

    // Find the pending slot at the current rank and whether the next rank exists
    always_comb begin
        any0 = 1'b0;
        any1 = 1'b0;
        sel  = '0;
        for (int i = 0; i < PENDING_DEPTH; i++) begin
            if (r_q_valid[i] && ({1'b0, r_q_rank[i]} == r_rank)) begin
                any0 = 1'b1;
                sel  = PAW'(i);
            end
            if (r_q_valid[i] && ({1'b0, r_q_rank[i]} == r_rank + (PAW+1)'(1))) begin
                any1 = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_INSERT || i_cmd == CMD_QUEUE) begin
                        n_state = S_PSCAN;
                    end else begin
                        n_state = S_CSCAN;
                    end
                end
            end
            S_PSCAN: begin
                if (pscan_end) begin
                    n_state = S_PUPD;
                end
            end
            S_PUPD: begin
                n_state = (r_cmd == CMD_INSERT) ? S_CSCAN : S_IDLE;
            end
            S_CSCAN: begin
                if (cscan_done) begin
                    n_state = (r_cmd == CMD_TICK) ? S_TWALK : S_IDLE;
                end
            end
            S_TWALK: begin
                if (!any0 || !any1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cidx     = r_cidx;
        n_pv       = 1'b0;
        n_paddr    = r_paddr;
        n_hit      = r_hit;
        n_hmac     = r_hmac;
        n_stored   = r_stored;
        n_pidx     = r_pidx;
        n_pmatch   = r_pmatch;
        n_pslot    = r_pslot;
        n_pfree_ok = r_pfree_ok;
        n_pfree    = r_pfree;
        n_rank     = r_rank;
        n_next     = r_next;
        n_q_valid  = r_q_valid;
        n_q_ip     = r_q_ip;
        n_q_sends  = r_q_sends;
        n_q_rank   = r_q_rank;
        n_out_stb  = 1'b0;
        n_kind     = r_kind;
        n_found    = r_found;
        n_ostored  = r_ostored;
        n_qs       = r_qs;
        n_omac     = r_omac;
        n_oip      = r_oip;
        n_last     = r_last;
        cctl           = '0;
        cctl.rd_addr   = 8'(r_cidx[CAW-1:0]);
        cctl.wr_addr   = 8'(r_paddr);
        cctl.wr_ip     = r_ip;
        cctl.wr_mac    = r_mac;
        cctl.wr_age    = age_inc[15:0];

        case (r_state)
            S_IDLE: begin
                n_cidx     = '0;
                n_pidx     = '0;
                n_hit      = 1'b0;
                n_hmac     = '0;
                n_stored   = 1'b0;
                n_pmatch   = 1'b0;
                n_pfree_ok = 1'b0;
                n_rank     = '0;
                n_next     = '0;
            end
            S_PSCAN: begin
                if (r_q_valid[r_pidx]) begin
                    if (r_q_ip[r_pidx] == r_ip && !r_pmatch) begin
                        n_pmatch = 1'b1;
                        n_pslot  = r_pidx;
                    end
                end else if (!r_pfree_ok) begin
                    n_pfree_ok = 1'b1;
                    n_pfree    = r_pidx;
                end
                n_pidx = r_pidx + PAW'(1);
            end
            S_PUPD: begin
                if (r_cmd == CMD_INSERT) begin
                    // drop the answered request and close its rank gap
                    if (r_pmatch) begin
                        for (int i = 0; i < PENDING_DEPTH; i++) begin
                            if (r_q_valid[i] && r_q_rank[i] > r_q_rank[r_pslot]) begin
                                n_q_rank[i] = r_q_rank[i] - PAW'(1);
                            end
                        end
                        n_q_valid[r_pslot] = 1'b0;
                    end
                end else begin
                    n_out_stb = 1'b1;
                    n_kind    = KIND_QUEUE;
                    n_found   = 1'b0;
                    n_ostored = 1'b0;
                    n_omac    = '0;
                    n_oip     = '0;
                    n_last    = 1'b1;
                    if (r_pmatch) begin
                        n_qs = QS_PENDING;
                    end else if (r_pfree_ok) begin
                        n_qs = QS_NEW;
                        for (int i = 0; i < PENDING_DEPTH; i++) begin
                            if (r_q_valid[i]) begin
                                n_q_rank[i] = r_q_rank[i] + PAW'(1);
                            end
                        end
                        n_q_valid[r_pfree] = 1'b1;
                        n_q_ip[r_pfree]    = r_ip;
                        n_q_sends[r_pfree] = '0;
                        n_q_rank[r_pfree]  = '0;
                    end else begin
                        n_qs = QS_FULL;
                    end
                end
            end
            S_CSCAN: begin
                // issue one read per cycle, handle the beat read the cycle before
                if (r_cidx != (CAW+1)'(CACHE_DEPTH)) begin
                    n_pv    = 1'b1;
                    n_paddr = r_cidx[CAW-1:0];
                    n_cidx  = r_cidx + (CAW+1)'(1);
                end
                if (r_pv) begin
                    case (r_cmd)
                        CMD_LOOKUP: begin
                            if (c_valid && c_ip == r_ip) begin
                                n_hit  = 1'b1;
                                n_hmac = c_mac;
                            end
                        end
                        CMD_INSERT: begin
                            if (!c_valid && !r_stored) begin
                                n_stored     = 1'b1;
                                cctl.wr_new  = 1'b1;
                                cctl.wr_age  = '0;
                            end
                        end
                        CMD_TICK: begin
                            if (c_valid) begin
                                if (age_inc > {1'b0, r_timeout}) begin
                                    cctl.clr = 1'b1;
                                end else begin
                                    cctl.wr_age_en = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                if (cscan_done && r_cmd != CMD_TICK) begin
                    n_out_stb = 1'b1;
                    n_qs      = QS_NEW;
                    n_oip     = '0;
                    n_last    = 1'b1;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_kind    = KIND_LOOKUP;
                        n_found   = r_hit;
                        n_ostored = 1'b0;
                        n_omac    = r_hit ? r_hmac : '0;
                    end else begin
                        n_kind    = KIND_INSERT;
                        n_found   = r_pmatch;
                        n_ostored = r_stored;
                        n_omac    = '0;
                    end
                end
            end
            S_TWALK: begin
                if (any0) begin
                    n_out_stb = 1'b1;
                    n_found   = 1'b0;
                    n_ostored = 1'b0;
                    n_qs      = QS_NEW;
                    n_omac    = '0;
                    n_oip     = r_q_ip[sel];
                    n_last    = !any1;
                    if (r_q_sends[sel] >= r_max) begin
                        n_kind         = KIND_UNREACH;
                        n_q_valid[sel] = 1'b0;
                    end else begin
                        n_kind         = KIND_SEND;
                        n_q_sends[sel] = r_q_sends[sel] + 4'd1;
                        n_q_rank[sel]  = r_next;
                        n_next         = r_next + PAW'(1);
                    end
                    n_rank = r_rank + (PAW+1)'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_max     <= MAX_SENDS_RESET;
            r_q_valid <= '0;
            r_out_stb <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_q_valid <= n_q_valid;
            r_out_stb <= n_out_stb;
            r_pv      <= n_pv;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ENTRY_TIMEOUT) begin
                    r_timeout <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_MAX_SENDS) begin
                    r_max <= i_cfg_wdata[3:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_ip  <= i_ip;
            r_mac <= i_mac;
        end
        r_cidx     <= n_cidx;
        r_paddr    <= n_paddr;
        r_hit      <= n_hit;
        r_hmac     <= n_hmac;
        r_stored   <= n_stored;
        r_pidx     <= n_pidx;
        r_pmatch   <= n_pmatch;
        r_pslot    <= n_pslot;
        r_pfree_ok <= n_pfree_ok;
        r_pfree    <= n_pfree;
        r_rank     <= n_rank;
        r_next     <= n_next;
        r_q_ip     <= n_q_ip;
        r_q_sends  <= n_q_sends;
        r_q_rank   <= n_q_rank;
        r_kind     <= n_kind;
        r_found    <= n_found;
        r_ostored  <= n_ostored;
        r_qs       <= n_qs;
        r_omac     <= n_omac;
        r_oip      <= n_oip;
        r_last     <= n_last;
    end

    assign o_valid        = r_out_stb;
    assign o_kind         = r_kind;
    assign o_found        = r_found;
    assign o_stored       = r_ostored;
    assign o_queue_status = r_qs;
    assign o_mac_out      = r_omac;
    assign o_ip_out       = r_oip;
    assign o_last         = r_last;

endmodule
